// File: rtl/tlbff_pkg.sv
`default_nettype none

package tlbff_pkg;

  // Address split: 1 KiB pages
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned PAGE_SHIFT  = 10;
  localparam int unsigned PAGE_W      = ADDR_W - PAGE_SHIFT;
  localparam int unsigned DATE_W      = 32;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned ENTRIES_DEF = 8;

  // One stored entry: {fill date, frame, page tag}
  localparam int unsigned ENTRY_W = DATE_W + PAGE_W + PAGE_W;

  // Request kinds on the mode input
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_FILL   = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Per-entry compare result
  typedef struct packed {
    logic tag_eq;  // page tag equals request page
    logic hit;     // tag equal and entry valid
    logic free;    // entry not valid
    logic older;   // fill date strictly below best so far
  } cmp_res_t;

endpackage

`default_nettype wire

// File: rtl/tlbff_ram.sv
`default_nettype none

module tlbff_ram #(
  parameter int unsigned WIDTH = tlbff_pkg::ENTRY_W,
  parameter int unsigned DEPTH = tlbff_pkg::ENTRIES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/tlbff_cmp.sv
`default_nettype none

module tlbff_cmp (
  input  wire logic                          ent_valid_i,
  input  wire logic [tlbff_pkg::PAGE_W-1:0]  ent_tag_i,
  input  wire logic [tlbff_pkg::DATE_W-1:0]  ent_date_i,
  input  wire logic [tlbff_pkg::PAGE_W-1:0]  page_i,
  input  wire logic [tlbff_pkg::DATE_W-1:0]  best_date_i,
  output tlbff_pkg::cmp_res_t                res_o
);

  import tlbff_pkg::*;

  logic [PAGE_W-1:0] tag;
  logic [DATE_W-1:0] date;

  // Never-written entries read as zero
  always_comb begin
    tag  = ent_valid_i ? ent_tag_i  : '0;
    date = ent_valid_i ? ent_date_i : '0;
    res_o.tag_eq = (tag == page_i);
    res_o.hit    = (tag == page_i) && ent_valid_i;
    res_o.free   = !ent_valid_i;
    res_o.older  = (date < best_date_i);
  end

endmodule

`default_nettype wire

// File: rtl/tlb_lookup_fifo_fill.sv
// Fully associative translation buffer, 1 KiB pages, FIFO replacement.
// Request channel: in_valid_i / in_stall_o with mode_i, virtual_address_i,
// fill_physical_address_i and timestamp_i. mode_i low is a lookup, high a fill.
// Response channel: out_valid_o / out_stall_i with physical_address_o, hit_o
// and slot_o; every request yields exactly one response.
// One request at a time: the entries sit in a RAM with one write and one read
// port and are read one per cycle, each checked by one shared compare unit.
// A request passes through accept, a scan whose RAM read is registered, and a
// response step; a lookup that matches early or a fill that finds a free entry
// ends the scan early.
// in_stall_o is high from accept until the response is loaded into the
// output register. A response waiting under out_stall_i holds its payload,
// and the next request is taken while it waits; only a second finished
// response stalls behind it.
// Reset clears all valid bits, so every entry reads as tag and date zero until
// filled; no clearing pass is needed. Entry RAM is not reset.
`default_nettype none

module tlb_lookup_fifo_fill #(
  parameter int unsigned ENTRIES = tlbff_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [tlbff_pkg::ADDR_W-1:0]  virtual_address_i,
  input  wire logic [tlbff_pkg::ADDR_W-1:0]  fill_physical_address_i,
  input  wire logic [tlbff_pkg::DATE_W-1:0]  timestamp_i,
  // response channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [tlbff_pkg::ADDR_W-1:0]  physical_address_o,
  output logic                               hit_o,
  output logic      [tlbff_pkg::SLOT_W-1:0]  slot_o
);

  import tlbff_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  // Control state
  state_e          state_q, state_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [ENTRIES-1:0] valid_q;
  logic            out_vld_q, out_vld_d;

  // Payload registers
  logic              req_mode_q;
  logic [ADDR_W-1:0] req_va_q;
  logic [PAGE_W-1:0] req_frame_q;
  logic [DATE_W-1:0] req_date_q;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic [DATE_W-1:0] best_date_q, best_date_d;
  logic              res_hit_q, res_hit_d;
  logic [AW-1:0]     res_slot_q, res_slot_d;
  logic [PAGE_W-1:0] res_frame_q, res_frame_d;
  logic [ADDR_W-1:0] out_pa_q;
  logic              out_hit_q;
  logic [SLOT_W-1:0] out_slot_q;

  // RAM and compare wiring
  logic              ram_re, ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
  logic [PAGE_W-1:0] ent_tag, ent_frame, req_page;
  logic [DATE_W-1:0] ent_date;
  logic              ent_valid;
  cmp_res_t          cmp_res;
  logic              in_acc, out_load;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign req_page = req_va_q[ADDR_W-1:PAGE_SHIFT];

  // Entry fields of the word read last cycle
  assign ent_tag   = ram_rdata[PAGE_W-1:0];
  assign ent_frame = ram_rdata[2*PAGE_W-1:PAGE_W];
  assign ent_date  = ram_rdata[ENTRY_W-1:2*PAGE_W];
  assign ent_valid = valid_q[cmp_idx_q];
  assign ram_wdata = {req_date_q, req_frame_q, req_page};

  tlbff_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (res_slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tlbff_cmp u_cmp (
    .ent_valid_i (ent_valid),
    .ent_tag_i   (ent_tag),
    .ent_date_i  (ent_date),
    .page_i      (req_page),
    .best_date_i (best_date_q),
    .res_o       (cmp_res)
  );

  // Sequencer: scan entries one per cycle, then hand off the response
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    best_idx_d  = best_idx_q;
    best_date_d = best_date_q;
    res_hit_d   = res_hit_q;
    res_slot_d  = res_slot_q;
    res_frame_d = res_frame_q;
    ram_re      = 1'b0;
    ram_raddr   = idx_q[AW-1:0];
    ram_we      = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d     = '0;
          res_hit_d = 1'b0;
          state_d   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue the next read
        if (idx_q < CW'(ENTRIES)) begin
          ram_re    = 1'b1;
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[AW-1:0];
        end
        // check the entry read last cycle
        if (cmp_vld_q) begin
          if (req_mode_q == MODE_LOOKUP) begin
            if (cmp_res.tag_eq) begin
              res_hit_d   = cmp_res.hit;
              res_slot_d  = cmp_idx_q;
              res_frame_d = ent_frame;
              cmp_vld_d   = 1'b0;
              state_d     = ST_RESP;
            end else if (cmp_idx_q == LAST_IDX) begin
              res_hit_d  = 1'b0;
              res_slot_d = '0;
              cmp_vld_d  = 1'b0;
              state_d    = ST_RESP;
            end
          end else begin
            if (cmp_res.free) begin
              res_slot_d = cmp_idx_q;
              cmp_vld_d  = 1'b0;
              state_d    = ST_RESP;
            end else begin
              if (cmp_idx_q == '0 || cmp_res.older) begin
                best_idx_d  = cmp_idx_q;
                best_date_d = ent_date;
              end
              if (cmp_idx_q == LAST_IDX) begin
                res_slot_d = cmp_res.older ? cmp_idx_q : best_idx_q;
                cmp_vld_d  = 1'b0;
                state_d    = ST_RESP;
              end
            end
          end
        end
      end

      ST_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          ram_we   = (req_mode_q == MODE_FILL);
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when taken
  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      out_vld_q <= out_vld_d;
      if (ram_we) begin
        valid_q[res_slot_q] <= 1'b1;
      end
    end
  end

  // Request capture and scan payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_mode_q  <= mode_i;
      req_va_q    <= virtual_address_i;
      req_frame_q <= fill_physical_address_i[ADDR_W-1:PAGE_SHIFT];
      req_date_q  <= timestamp_i;
    end
    best_idx_q  <= best_idx_d;
    best_date_q <= best_date_d;
    res_hit_q   <= res_hit_d;
    res_slot_q  <= res_slot_d;
    res_frame_q <= res_frame_d;
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q  <= (req_mode_q == MODE_LOOKUP) && res_hit_q;
      out_slot_q <= SLOT_W'(res_slot_q);
      if ((req_mode_q == MODE_LOOKUP) && res_hit_q) begin
        out_pa_q <= {res_frame_q, req_va_q[PAGE_SHIFT-1:0]};
      end else begin
        out_pa_q <= '0;
      end
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_vld_q;
  assign physical_address_o = out_pa_q;
  assign hit_o              = out_hit_q;
  assign slot_o             = out_slot_q;

endmodule

`default_nettype wire

// File: test/tlb_lookup_fifo_fill_tb.sv
`timescale 1ns / 100ps

module tlb_lookup_fifo_fill_tb;
  import tlbff_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEF;
  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned MAX_WAIT    = 11;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned DIR_ROWS    = 23;
  localparam int unsigned POOL_N      = 12;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam logic        FIXED       = 1'b1;  // expected response typed in the row
  localparam logic        MODELED     = 1'b0;  // expected response from the predictor

  typedef struct packed {
    logic [ADDR_W-1:0] phys;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } xlat_rsp_t;

  // one row of the directed table
  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;
    logic [DATE_W-1:0] ts;
    logic              fixed_exp;
    logic [ADDR_W-1:0] exp_phys;
    logic              exp_hit;
    logic [SLOT_W-1:0] exp_slot;
  } dir_row_t;

  logic              clk_i                   = 1'b0;
  logic              rst_ni                  = 1'b0;
  logic              in_valid_i              = 1'b0;
  logic              in_stall_o;
  logic              mode_i                  = MODE_LOOKUP;
  logic [ADDR_W-1:0] virtual_address_i       = '0;
  logic [ADDR_W-1:0] fill_physical_address_i = '0;
  logic [DATE_W-1:0] timestamp_i             = '0;
  logic              out_valid_o;
  logic              out_stall_i             = 1'b0;
  logic [ADDR_W-1:0] physical_address_o;
  logic              hit_o;
  logic [SLOT_W-1:0] slot_o;

  // predicted translation buffer contents
  logic [PAGE_W-1:0] tlb_tag   [ENTRIES];
  logic [PAGE_W-1:0] tlb_frame [ENTRIES];
  logic              tlb_valid [ENTRIES];
  logic [DATE_W-1:0] tlb_date  [ENTRIES];

  xlat_rsp_t pending_rsp_q [$];

  int unsigned mismatches     = 0;
  int unsigned requests_sent  = 0;
  int unsigned fills_sent     = 0;
  int unsigned responses_seen = 0;
  int unsigned hits_seen      = 0;
  int unsigned stalled_offers = 0;
  int unsigned idle_cycles    = 0;
  bit          send_no_gaps   = 1'b0;
  bit          drain_fast     = 1'b0;
  bit          hold_out_req   = 1'b0;

  tlb_lookup_fifo_fill u_top (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .mode_i                  (mode_i),
    .virtual_address_i       (virtual_address_i),
    .fill_physical_address_i (fill_physical_address_i),
    .timestamp_i             (timestamp_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .physical_address_o      (physical_address_o),
    .hit_o                   (hit_o),
    .slot_o                  (slot_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Lookup: first tag match decides. Fill: first free entry, else strictly oldest date.
  function automatic xlat_rsp_t translate_or_fill(input logic              mode,
                                                  input logic [ADDR_W-1:0] va,
                                                  input logic [ADDR_W-1:0] pa,
                                                  input logic [DATE_W-1:0] ts);
    xlat_rsp_t         rsp;
    logic [PAGE_W-1:0] page;
    logic [DATE_W-1:0] oldest;
    logic              done;
    int unsigned       victim;
    rsp  = '0;
    page = va[ADDR_W-1:PAGE_SHIFT];
    done = 1'b0;
    if (mode == MODE_LOOKUP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!done && tlb_tag[i] == page) begin
          done     = 1'b1;
          rsp.slot = SLOT_W'(i);
          if (tlb_valid[i]) begin
            rsp.hit  = 1'b1;
            rsp.phys = {tlb_frame[i], va[PAGE_SHIFT-1:0]};
          end
        end
      end
    end else begin
      victim = 0;
      oldest = tlb_date[0];
      for (int i = 0; i < ENTRIES; i++) begin
        if (!done) begin
          if (!tlb_valid[i]) begin
            victim = i;
            done   = 1'b1;
          end else if (tlb_date[i] < oldest) begin
            oldest = tlb_date[i];
            victim = i;
          end
        end
      end
      tlb_tag[victim]   = page;
      tlb_frame[victim] = pa[ADDR_W-1:PAGE_SHIFT];
      tlb_valid[victim] = 1'b1;
      tlb_date[victim]  = ts;
      rsp.slot          = SLOT_W'(victim);
    end
    return rsp;
  endfunction

  task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
                               input logic [ADDR_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one request after a random gap; record the expected response on accept.
  task automatic send_request(input logic              mode,
                              input logic [ADDR_W-1:0] va,
                              input logic [ADDR_W-1:0] pa,
                              input logic [DATE_W-1:0] ts,
                              input logic              fixed_exp,
                              input xlat_rsp_t         fixed_rsp);
    int unsigned gap;
    xlat_rsp_t   pred;
    gap = send_no_gaps ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i              <= 1'b0;
      virtual_address_i       <= $urandom;
      fill_physical_address_i <= $urandom;
      timestamp_i             <= $urandom;
      mode_i                  <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i              <= 1'b1;
    mode_i                  <= mode;
    virtual_address_i       <= va;
    fill_physical_address_i <= pa;
    timestamp_i             <= ts;
    do @(posedge clk_i); while (in_stall_o);
    pred = translate_or_fill(mode, va, pa, ts);
    pending_rsp_q.push_back(fixed_exp ? fixed_rsp : pred);
    requests_sent++;
    if (mode == MODE_FILL) fills_sent++;
  endtask

  // Response side: random stall per response, one long hold on request.
  initial begin : rsp_drain
    int unsigned waits;
    wait (rst_ni);
    forever begin
      waits = drain_fast ? 0 : $urandom_range(MAX_WAIT, 0);
      if (hold_out_req) begin
        waits        = HOLD_CYCLES;
        hold_out_req = 1'b0;
      end
      if (waits != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (waits - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Response checker
  always @(posedge clk_i) begin : rsp_check
    xlat_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      responses_seen++;
      if (pending_rsp_q.size() == 0) begin
        flag_mismatch("response with no request pending", physical_address_o, '0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (want.hit) hits_seen++;
        if (physical_address_o !== want.phys)
          flag_mismatch("physical_address", physical_address_o, want.phys);
        if (hit_o !== want.hit)
          flag_mismatch("hit", ADDR_W'(hit_o), ADDR_W'(want.hit));
        if (slot_o !== want.slot)
          flag_mismatch("slot", ADDR_W'(slot_o), ADDR_W'(want.slot));
      end
    end
  end

  // Watchdog on cycles without any handshake; also counts back-pressured offers
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o) stalled_offers++;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles, %0d responses outstanding",
                 $time, IDLE_LIMIT, pending_rsp_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t          rows      [DIR_ROWS];
    logic [PAGE_W-1:0] page_pool [POOL_N];
    xlat_rsp_t         row_rsp;
    logic              mode;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;
    logic [DATE_W-1:0] ts;
    logic [DATE_W-1:0] date_ctr;

    // predictor starts from the reset contents
    for (int i = 0; i < ENTRIES; i++) begin
      tlb_tag[i]   = '0;
      tlb_frame[i] = '0;
      tlb_valid[i] = 1'b0;
      tlb_date[i]  = '0;
    end

    // directed table: mode, va, pa, date, source of expectation, phys, hit, slot
    // all tags read zero after reset, so page 0 matches an invalid entry
    rows[0]  = '{MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 FIXED, 32'h0, 1'b0, 3'd0};
    // no tag matches; unused fields at all ones
    rows[1]  = '{MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 FIXED, 32'h0, 1'b0, 3'd0};
    rows[2]  = '{MODE_FILL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 FIXED, 32'h0, 1'b0, 3'd0};
    rows[3]  = '{MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                 FIXED, 32'hFFFF_FFFF, 1'b1, 3'd0};
    rows[4]  = '{MODE_LOOKUP, 32'hFFFF_FC00, 32'h0000_0000, 32'h0000_0000,
                 FIXED, 32'hFFFF_FC00, 1'b1, 3'd0};
    // page 0 now first matches invalid entry 1
    rows[5]  = '{MODE_LOOKUP, 32'h0000_03FF, 32'h0000_0000, 32'h0000_0000,
                 FIXED, 32'h0, 1'b0, 3'd1};
    rows[6]  = '{MODE_FILL,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 FIXED, 32'h0, 1'b0, 3'd1};
    rows[7]  = '{MODE_LOOKUP, 32'h0000_03FF, 32'h0000_0000, 32'h0000_0000,
                 FIXED, 32'h0000_03FF, 1'b1, 3'd1};
    rows[8]  = '{MODE_FILL,   32'h1234_5400, 32'hABCD_E800, 32'h0000_0005,
                 FIXED, 32'h0, 1'b0, 3'd2};
    rows[9]  = '{MODE_LOOKUP, 32'h1234_57FF, 32'h0000_0000, 32'h0000_0000,
                 MODELED, 32'h0, 1'b0, 3'd0};
    rows[10] = '{MODE_FILL,   32'h5555_5400, 32'hAAAA_A800, 32'h0000_0005,
                 FIXED, 32'h0, 1'b0, 3'd3};
    rows[11] = '{MODE_FILL,   32'hAAAA_A800, 32'h5555_5400, 32'h0000_0003,
                 FIXED, 32'h0, 1'b0, 3'd4};
    rows[12] = '{MODE_FILL,   32'h0000_0400, 32'h0000_1000, 32'h0000_0007,
                 FIXED, 32'h0, 1'b0, 3'd5};
    rows[13] = '{MODE_FILL,   32'h0000_0800, 32'h7FFF_FC00, 32'h0000_0007,
                 FIXED, 32'h0, 1'b0, 3'd6};
    rows[14] = '{MODE_FILL,   32'h0000_0C00, 32'h8000_0000, 32'h0000_0001,
                 FIXED, 32'h0, 1'b0, 3'd7};
    // buffer full: replacement by oldest date, date ties go to the lower index
    rows[15] = '{MODE_FILL,   32'h0000_1000, 32'h0000_F000, 32'h0000_000A,
                 MODELED, 32'h0, 1'b0, 3'd0};
    rows[16] = '{MODE_FILL,   32'h0000_1400, 32'h1234_5678, 32'h0000_000A,
                 MODELED, 32'h0, 1'b0, 3'd0};
    rows[17] = '{MODE_FILL,   32'h0000_1800, 32'h0000_0000, 32'h0000_000B,
                 MODELED, 32'h0, 1'b0, 3'd0};
    rows[18] = '{MODE_FILL,   32'h0000_1C00, 32'hFFFF_F000, 32'h0000_000C,
                 MODELED, 32'h0, 1'b0, 3'd0};
    rows[19] = '{MODE_LOOKUP, 32'h0000_03FF, 32'h0000_0000, 32'h0000_0000,
                 MODELED, 32'h0, 1'b0, 3'd0};
    rows[20] = '{MODE_LOOKUP, 32'h5555_5555, 32'h0000_0000, 32'h0000_0000,
                 MODELED, 32'h0, 1'b0, 3'd0};
    // refill of a page already present
    rows[21] = '{MODE_FILL,   32'h5555_5400, 32'hC000_0000, 32'h0000_0014,
                 MODELED, 32'h0, 1'b0, 3'd0};
    rows[22] = '{MODE_LOOKUP, 32'h0000_05A5, 32'h0000_0000, 32'h0000_0000,
                 MODELED, 32'h0, 1'b0, 3'd0};

    // reset
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    for (int r = 0; r < DIR_ROWS; r++) begin
      row_rsp = '{rows[r].exp_phys, rows[r].exp_hit, rows[r].exp_slot};
      send_request(rows[r].mode, rows[r].va, rows[r].pa, rows[r].ts,
                   rows[r].fixed_exp, row_rsp);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);

    // random part: pages mostly from a pool a bit larger than the buffer
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) page_pool[i] = PAGE_W'($urandom);
    date_ctr = 32'd100;
    for (int p = 0; p < PHASES; p++) begin
      send_no_gaps = (p % 3 == 0);
      drain_fast   = (p % 3 == 1);
      if (p == 2) begin
        // response side holds off while requests keep coming
        send_no_gaps = 1'b1;
        hold_out_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = ($urandom_range(99, 0) < 35) ? MODE_FILL : MODE_LOOKUP;
        if ($urandom_range(3, 0) != 0)
          va = {page_pool[$urandom_range(POOL_N - 1, 0)], PAGE_SHIFT'($urandom)};
        else
          va = $urandom;
        pa = $urandom;
        case ($urandom_range(3, 0))
          0, 1: begin
            date_ctr = date_ctr + $urandom_range(1, 0);
            ts       = date_ctr;
          end
          2: begin
            case ($urandom_range(3, 0))
              0:       ts = '0;
              1:       ts = 32'd1;
              2:       ts = '1;
              default: ts = 32'hFFFF_FFFE;
            endcase
          end
          default: ts = $urandom;
        endcase
        send_request(mode, va, pa, ts, MODELED, '0);
      end
      if (p == 4) begin
        // sender pauses until every response is back
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then allow for stray responses
    drain_fast = 1'b1;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (2 * ENTRIES + 8) @(posedge clk_i);

    $display("Sent %0d requests (%0d fills, %0d lookups), %0d responses, %0d hits.",
             requests_sent, fills_sent, requests_sent - fills_sent, responses_seen,
             hits_seen);
    $display("Input held off for %0d cycles under back-pressure; %0d mismatches.",
             stalled_offers, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
